>>> hdl/drc_pkg.sv
`timescale 1ns / 1ps

package drc_pkg;

  // Default geometry of the map and the screen.
  localparam int MapSizeDef = 32;
  localparam int ScreenWDef = 640;
  localparam int ScreenHDef = 640;

  // Fixed arithmetic widths.
  localparam int NumW = 29;   // widest dividend: 2^28 for the reciprocals
  localparam int CxW = 23;    // camera offset, signed Q.14
  localparam int RayW = 27;   // ray component, signed Q.14
  localparam int DltW = 49;   // delta, up to 2^48
  localparam int OneQ14 = 16384;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CAM_X   = 3'd0,
    REG_CAM_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5,
    REG_RSVD_6  = 3'd6,
    REG_RSVD_7  = 3'd7
  } drc_reg_e;

  localparam logic [12:0] CamXRst = 13'd2560;
  localparam logic [12:0] CamYRst = 13'd3584;
  localparam logic signed [15:0] DirXRst = -16'sd16384;
  localparam logic signed [15:0] DirYRst = 16'sd0;
  localparam logic signed [15:0] PlaneXRst = 16'sd0;
  localparam logic signed [15:0] PlaneYRst = 16'sd10813;

  // Input action codes.
  localparam logic ActWrite = 1'b0;
  localparam logic ActCast = 1'b1;

  typedef struct packed {
    logic       action;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [7:0] cell_value;
    logic [9:0] column;
  } drc_in_t;

  typedef struct packed {
    logic [9:0] out_column;
    logic [9:0] span_start;
    logic [9:0] span_end;
    logic [7:0] wall_code;
    logic [2:0] palette_index;
    logic       hit_side;
  } drc_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CX,
    ST_RAYX,
    ST_RAYY,
    ST_DX,
    ST_DY,
    ST_SIDEX,
    ST_SIDEY,
    ST_STEP,
    ST_CHECK,
    ST_LINE,
    ST_SPAN
  } drc_state_e;

endpackage

>>> hdl/drc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module drc_div #(
  parameter int NUM_W = drc_pkg::NumW,
  parameter int DEN_W = 56
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Operand load on start, else one shift and subtract step while busy.
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    fits = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = '0;
      num_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      num_d = {num_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

>>> hdl/dda_raycast_column_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (drc_in_t)
// out       output     out_valid_o / out_stall_i out_data_o (drc_out_t)
// cfg       input      APB psel/penable/pready   pwdata / prdata
//
// A map write is done in the idle state. A cast runs three divisions (two
// reciprocals, line height; a zero operand skips its division), DDA steps
// (step, then map read) for up to 2*MAP_SIZE+4 steps, and the states CX,
// RAYX, RAYY, SIDEX, SIDEY and SPAN; the camera offset is a reciprocal multiply.
// After reset the map is swept to zero, while no item is accepted. A finished
// result waits in the output register while the next item is taken; a cast
// stalls at its end only if that register is full.
module dda_raycast_column_core #(
  parameter int MAP_SIZE = drc_pkg::MapSizeDef,
  parameter int SCREEN_WIDTH = drc_pkg::ScreenWDef,
  parameter int SCREEN_HEIGHT = drc_pkg::ScreenHDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  drc_pkg::drc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output drc_pkg::drc_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int Depth = MAP_SIZE * MAP_SIZE;
  localparam int AW = $clog2(Depth);
  localparam int XW = $clog2(MAP_SIZE);
  localparam int Limit = 2 * MAP_SIZE + 4;
  localparam int StW = $clog2(Limit + 1);
  localparam int CW = $clog2(32 + Limit) + 2;
  localparam int SumW = drc_pkg::DltW + $clog2(Limit + 2) + 1;
  localparam int DenW = SumW;
  localparam int LnW = $clog2(SCREEN_HEIGHT + 1) + 1;
  localparam int NumW = drc_pkg::NumW;
  localparam logic [LnW-1:0] ScrH = LnW'(SCREEN_HEIGHT);
  localparam logic [LnW-1:0] ScrH2 = LnW'(SCREEN_HEIGHT / 2);

  // Camera offset by reciprocal multiplication: the dividend column * 2^15
  // has 25 bits, so a 27-bit multiplier rounded up gives the exact floor.
  localparam int CxNumW = 25;
  localparam int CxShift = CxNumW - 15 + $clog2(SCREEN_WIDTH);
  localparam longint unsigned CxMulL =
    ((64'd1 << (CxNumW + $clog2(SCREEN_WIDTH))) + 64'(SCREEN_WIDTH) - 64'd1) /
    64'(SCREEN_WIDTH);
  localparam logic [26:0] CxMul = 27'(CxMulL);

  // Configuration registers.
  logic [12:0]        cam_x_q, cam_y_q;
  logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic               cfg_we;
  drc_pkg::drc_reg_e  cfg_idx;

  // Cast state.
  drc_pkg::drc_state_e state_q, state_d;
  logic [9:0]              col_q, col_d;
  logic signed [drc_pkg::CxW-1:0]  cx_q, cx_d;
  logic signed [drc_pkg::RayW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [drc_pkg::DltW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [SumW-1:0]         sdx_q, sdx_d, sdy_q, sdy_d;
  logic signed [CW-1:0]    mx_q, mx_d, my_q, my_d;
  logic                    side_q, side_d;
  logic [7:0]              code_q, code_d;
  logic [StW-1:0]          steps_q, steps_d;
  logic [LnW-1:0]          line_q, line_d;
  logic                    launched_q, launched_d;
  logic [AW-1:0]           clr_q, clr_d;
  drc_pkg::drc_out_t       out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  // Datapath nets.
  logic                    in_acc;
  logic [36:0]             cx_prod;
  logic signed [15:0]      mul_plane;
  logic signed [drc_pkg::CxW+15:0] ray_prod;
  logic signed [drc_pkg::RayW-1:0] ray_new;
  logic [8:0]              frac;
  logic [drc_pkg::DltW+8:0] side_prod;
  logic                    step_x;
  logic signed [CW-1:0]    nmx, nmy;
  logic                    off_grid;
  logic [SumW-1:0]         perp;
  logic [LnW-1:0]          span_s, span_e;
  logic                    out_free;
  logic                    div_start, div_done;
  logic [NumW-1:0]         div_num, div_quot;
  logic [DenW-1:0]         div_den;
  logic [DenW-1:0]         rx_abs, ry_abs;

  // Map memory ports.
  logic [7:0]    mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, rd_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign cfg_idx = drc_pkg::drc_reg_e'(paddr[4:2]);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= drc_pkg::CamXRst;
      cam_y_q <= drc_pkg::CamYRst;
      dir_x_q <= drc_pkg::DirXRst;
      dir_y_q <= drc_pkg::DirYRst;
      plane_x_q <= drc_pkg::PlaneXRst;
      plane_y_q <= drc_pkg::PlaneYRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        drc_pkg::REG_CAM_X:   cam_x_q <= pwdata[12:0];
        drc_pkg::REG_CAM_Y:   cam_y_q <= pwdata[12:0];
        drc_pkg::REG_DIR_X:   dir_x_q <= pwdata[15:0];
        drc_pkg::REG_DIR_Y:   dir_y_q <= pwdata[15:0];
        drc_pkg::REG_PLANE_X: plane_x_q <= pwdata[15:0];
        drc_pkg::REG_PLANE_Y: plane_y_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_idx)
      drc_pkg::REG_CAM_X:   prdata = {19'd0, cam_x_q};
      drc_pkg::REG_CAM_Y:   prdata = {19'd0, cam_y_q};
      drc_pkg::REG_DIR_X:   prdata = {16'd0, dir_x_q};
      drc_pkg::REG_DIR_Y:   prdata = {16'd0, dir_y_q};
      drc_pkg::REG_PLANE_X: prdata = {16'd0, plane_x_q};
      drc_pkg::REG_PLANE_Y: prdata = {16'd0, plane_y_q};
      default:              prdata = '0;
    endcase
  end

  assign in_stall_o = state_q != drc_pkg::ST_IDLE;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Camera offset numerator scaled by the reciprocal of the screen width.
  assign cx_prod = col_q * CxMul;

  // Shared ray multiplier: ray = dir + floor(plane * cx / 2^14).
  assign mul_plane = (state_q == drc_pkg::ST_RAYX) ? plane_x_q : plane_y_q;
  assign ray_prod = mul_plane * cx_q;
  always_comb begin
    if (state_q == drc_pkg::ST_RAYX) begin
      ray_new = drc_pkg::RayW'(dir_x_q) + drc_pkg::RayW'(ray_prod >>> 14);
    end else begin
      ray_new = drc_pkg::RayW'(dir_y_q) + drc_pkg::RayW'(ray_prod >>> 14);
    end
  end

  assign rx_abs = (rx_q < 0) ? DenW'(-rx_q) : DenW'(rx_q);
  assign ry_abs = (ry_q < 0) ? DenW'(-ry_q) : DenW'(ry_q);

  // Initial side distance: distance fraction times delta, Q.8.
  always_comb begin
    if (state_q == drc_pkg::ST_SIDEX) begin
      frac = (rx_q < 0) ? {1'b0, cam_x_q[7:0]} : 9'd256 - {1'b0, cam_x_q[7:0]};
      side_prod = frac * dx_q;
    end else begin
      frac = (ry_q < 0) ? {1'b0, cam_y_q[7:0]} : 9'd256 - {1'b0, cam_y_q[7:0]};
      side_prod = frac * dy_q;
    end
  end

  // One DDA step: advance on the axis with the nearer boundary.
  assign step_x = sdx_q < sdy_q;
  always_comb begin
    nmx = mx_q;
    nmy = my_q;
    if (step_x) begin
      nmx = (rx_q < 0) ? mx_q - CW'(1) : mx_q + CW'(1);
    end else begin
      nmy = (ry_q < 0) ? my_q - CW'(1) : my_q + CW'(1);
    end
  end
  assign off_grid = (nmx < 0) || (nmy < 0) || (nmx >= CW'(MAP_SIZE)) ||
                    (nmy >= CW'(MAP_SIZE));

  assign perp = side_q ? sdy_q - SumW'(dy_q) : sdx_q - SumW'(dx_q);

  // Divider operands by phase.
  always_comb begin
    unique case (state_q)
      drc_pkg::ST_DX: begin
        div_num = NumW'(1) << 28;
        div_den = rx_abs;
      end
      drc_pkg::ST_DY: begin
        div_num = NumW'(1) << 28;
        div_den = ry_abs;
      end
      default: begin
        div_num = NumW'(SCREEN_HEIGHT) << 14;
        div_den = perp;
      end
    endcase
  end

  // Vertical span from the line height.
  always_comb begin
    span_s = ScrH2 - (line_q >> 1);
    span_e = (line_q >> 1) + ScrH2;
    if (span_e >= ScrH) begin
      span_e = ScrH - LnW'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drc_pkg::ST_CLEAR: if (clr_q == AW'(Depth - 1)) state_d = drc_pkg::ST_IDLE;
      drc_pkg::ST_IDLE: begin
        if (in_acc && in_data_i.action == drc_pkg::ActCast) state_d = drc_pkg::ST_CX;
      end
      drc_pkg::ST_CX:    state_d = drc_pkg::ST_RAYX;
      drc_pkg::ST_RAYX:  state_d = drc_pkg::ST_RAYY;
      drc_pkg::ST_RAYY:  state_d = drc_pkg::ST_DX;
      drc_pkg::ST_DX:    if (rx_q == 0 || div_done) state_d = drc_pkg::ST_DY;
      drc_pkg::ST_DY:    if (ry_q == 0 || div_done) state_d = drc_pkg::ST_SIDEX;
      drc_pkg::ST_SIDEX: state_d = drc_pkg::ST_SIDEY;
      drc_pkg::ST_SIDEY: state_d = drc_pkg::ST_STEP;
      drc_pkg::ST_STEP:  state_d = off_grid ? drc_pkg::ST_LINE : drc_pkg::ST_CHECK;
      drc_pkg::ST_CHECK: begin
        if (rd_q != 8'd0 || steps_q == StW'(Limit)) begin
          state_d = drc_pkg::ST_LINE;
        end else begin
          state_d = drc_pkg::ST_STEP;
        end
      end
      drc_pkg::ST_LINE:  if (perp == '0 || div_done) state_d = drc_pkg::ST_SPAN;
      drc_pkg::ST_SPAN:  if (out_free) state_d = drc_pkg::ST_IDLE;
      default:           state_d = drc_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates, memory control and divider launch.
  always_comb begin
    col_d = col_q;
    cx_d = cx_q;
    rx_d = rx_q;
    ry_d = ry_q;
    dx_d = dx_q;
    dy_d = dy_q;
    sdx_d = sdx_q;
    sdy_d = sdy_q;
    mx_d = mx_q;
    my_d = my_q;
    side_d = side_q;
    code_d = code_q;
    steps_d = steps_q;
    line_d = line_q;
    launched_d = launched_q;
    clr_d = clr_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start = 1'b0;
    mem_we = 1'b0;
    mem_waddr = AW'(32'(in_data_i.cell_x) * MAP_SIZE + 32'(in_data_i.cell_y));
    mem_wdata = in_data_i.cell_value;
    mem_raddr = AW'(32'(nmx[XW-1:0]) * MAP_SIZE + 32'(nmy[XW-1:0]));
    if (div_done) launched_d = 1'b0;
    unique case (state_q)
      drc_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'd0;
        clr_d = clr_q + AW'(1);
      end
      drc_pkg::ST_IDLE: begin
        col_d = in_data_i.column;
        if (in_acc && in_data_i.action == drc_pkg::ActWrite &&
            32'(in_data_i.cell_x) < MAP_SIZE && 32'(in_data_i.cell_y) < MAP_SIZE) begin
          mem_we = 1'b1;
        end
        if (!in_acc) col_d = col_q;
      end
      drc_pkg::ST_CX: begin
        cx_d = $signed(drc_pkg::CxW'(cx_prod >> CxShift)) -
               $signed(drc_pkg::CxW'(drc_pkg::OneQ14));
      end
      drc_pkg::ST_RAYX: rx_d = ray_new;
      drc_pkg::ST_RAYY: ry_d = ray_new;
      drc_pkg::ST_DX: begin
        if (rx_q == 0) begin
          dx_d = drc_pkg::DltW'(1) << 48;
        end else begin
          div_start = !launched_q;
          if (div_start) launched_d = 1'b1;
          if (div_done) dx_d = drc_pkg::DltW'(div_quot);
        end
      end
      drc_pkg::ST_DY: begin
        if (ry_q == 0) begin
          dy_d = drc_pkg::DltW'(1) << 48;
        end else begin
          div_start = !launched_q;
          if (div_start) launched_d = 1'b1;
          if (div_done) dy_d = drc_pkg::DltW'(div_quot);
        end
      end
      drc_pkg::ST_SIDEX: begin
        sdx_d = SumW'(side_prod >> 8);
        mx_d = CW'(cam_x_q[12:8]);
      end
      drc_pkg::ST_SIDEY: begin
        sdy_d = SumW'(side_prod >> 8);
        my_d = CW'(cam_y_q[12:8]);
        steps_d = '0;
        side_d = 1'b0;
        code_d = 8'd0;
      end
      drc_pkg::ST_STEP: begin
        if (step_x) begin
          sdx_d = sdx_q + SumW'(dx_q);
          side_d = 1'b0;
        end else begin
          sdy_d = sdy_q + SumW'(dy_q);
          side_d = 1'b1;
        end
        mx_d = nmx;
        my_d = nmy;
        steps_d = steps_q + StW'(1);
        if (off_grid) code_d = 8'd0;
      end
      drc_pkg::ST_CHECK: code_d = rd_q;
      drc_pkg::ST_LINE: begin
        if (perp == '0) begin
          line_d = ScrH;
        end else begin
          div_start = !launched_q;
          if (div_start) launched_d = 1'b1;
          if (div_done) begin
            line_d = (div_quot > NumW'(SCREEN_HEIGHT)) ? ScrH : LnW'(div_quot);
          end
        end
      end
      drc_pkg::ST_SPAN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.out_column = col_q;
          out_d.span_start = 10'(span_s);
          out_d.span_end = 10'(span_e);
          out_d.wall_code = code_q;
          out_d.palette_index = (code_q >= 8'd1 && code_q <= 8'd4) ?
                                3'(code_q - 8'd1) : 3'd4;
          out_d.hit_side = side_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drc_pkg::ST_CLEAR;
      launched_q <= 1'b0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      launched_q <= launched_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    cx_q <= cx_d;
    rx_q <= rx_d;
    ry_q <= ry_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    sdx_q <= sdx_d;
    sdy_q <= sdy_d;
    mx_q <= mx_d;
    my_q <= my_d;
    side_q <= side_d;
    code_q <= code_d;
    line_q <= line_d;
    out_q <= out_d;
  end

  // Map memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  drc_div #(
    .NUM_W(NumW),
    .DEN_W(DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // The map is only written by the clearing sweep or a write item.
  a_mem_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == drc_pkg::ST_CLEAR || state_q == drc_pkg::ST_IDLE))
    else $error("map written during a cast");

  // A map check always follows a step that issued its read.
  a_check_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == drc_pkg::ST_CHECK |-> $past(state_q) == drc_pkg::ST_STEP)
    else $error("map check without a read");

  // The walk never runs past its step limit.
  a_step_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= StW'(Limit))
    else $error("step counter overrun");

  // A divider result only arrives for a launched division.
  a_div_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> launched_q)
    else $error("divider done without launch");

endmodule

>>> bench/dda_raycast_column_core_tb.sv
`timescale 1ns / 1ps

module dda_raycast_column_core_tb;

  localparam int MapSize = 32;
  localparam int ScreenW = 640;
  localparam int ScreenH = 640;
  localparam int InW = $bits(drc_pkg::drc_in_t);
  // Settling wait after the expected results have drained; writes give no result.
  localparam int CastSettle = 400;

  typedef struct {
    drc_pkg::drc_in_t  item;
    bit                typed;
    drc_pkg::drc_out_t want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  drc_pkg::drc_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  drc_pkg::drc_out_t out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow copy of the camera setup and the map.
  int          cam_x, cam_y, dir_x, dir_y, plane_x, plane_y;
  logic [7:0]  cell_map [0:MapSize*MapSize-1];

  drc_pkg::drc_out_t pending_spans[$];
  stim_row_t         stim_rows[$];
  int                mismatches;
  bit                long_hold_req;

  dda_raycast_column_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  // Reciprocal of a ray component in Q.14; a zero component is "infinite".
  function automatic longint unsigned inv_q14(input longint r);
    longint unsigned m;
    if (r == 0) begin
      return 64'd1 << 48;
    end
    m = (r < 0) ? -r : r;
    return (64'd1 << 28) / m;
  endfunction

  // Walk the grid for one screen column and form the wall stripe.
  function automatic drc_pkg::drc_out_t trace_column(input logic [9:0] col);
    longint            cx, rx, ry;
    longint unsigned   dx, dy, sdx, sdy, fx, fy, perp, line, sp_start, sp_end;
    int                mx, my, stx, sty, side, steps;
    logic [7:0]        code;
    bit                hit;
    drc_pkg::drc_out_t r;
    cx = (longint'(col) * 32768) / ScreenW - 16384;
    rx = longint'(dir_x) + ((longint'(plane_x) * cx) >>> 14);
    ry = longint'(dir_y) + ((longint'(plane_y) * cx) >>> 14);
    dx = inv_q14(rx);
    dy = inv_q14(ry);
    mx = cam_x >> 8;
    my = cam_y >> 8;
    fx = longint'(cam_x & 255);
    fy = longint'(cam_y & 255);
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    if (rx >= 0) fx = 256 - fx;
    if (ry >= 0) fy = 256 - fy;
    sdx = (fx * dx) >> 8;
    sdy = (fy * dy) >> 8;
    side = 0;
    code = 8'd0;
    hit = 1'b0;
    for (steps = 0; !hit && steps < 2 * MapSize + 4; steps++) begin
      if (sdx < sdy) begin
        sdx += dx;
        mx += stx;
        side = 0;
      end else begin
        sdy += dy;
        my += sty;
        side = 1;
      end
      if (mx < 0 || my < 0 || mx >= MapSize || my >= MapSize) begin
        code = 8'd0;
        hit = 1'b1;
      end else begin
        code = cell_map[mx*MapSize+my];
        hit = (code != 8'd0);
      end
    end
    perp = (side == 0) ? sdx - dx : sdy - dy;
    if (perp == 0) begin
      line = ScreenH;
    end else begin
      line = (longint'(ScreenH) << 14) / perp;
      if (line > ScreenH) line = ScreenH;
    end
    sp_start = ScreenH / 2 - line / 2;
    sp_end = line / 2 + ScreenH / 2;
    if (sp_end >= ScreenH) sp_end = ScreenH - 1;
    r.out_column = col;
    r.span_start = sp_start[9:0];
    r.span_end = sp_end[9:0];
    r.wall_code = code;
    r.palette_index = (code >= 1 && code <= 4) ? 3'(code - 1) : 3'd4;
    r.hit_side = side[0];
    return r;
  endfunction

  // Register write over the APB port; the shadow follows at the access edge.
  task automatic write_reg(input drc_pkg::drc_reg_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    unique case (idx)
      drc_pkg::REG_CAM_X:   cam_x = value[12:0];
      drc_pkg::REG_CAM_Y:   cam_y = value[12:0];
      drc_pkg::REG_DIR_X:   dir_x = $signed(value[15:0]);
      drc_pkg::REG_DIR_Y:   dir_y = $signed(value[15:0]);
      drc_pkg::REG_PLANE_X: plane_x = $signed(value[15:0]);
      drc_pkg::REG_PLANE_Y: plane_y = $signed(value[15:0]);
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every cast has returned and any trailing write has settled.
  task automatic drain();
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (CastSettle) @(posedge clk_i);
  endtask

  task automatic load_camera(input int cx, cy, dxv, dyv, px, py);
    drain();
    write_reg(drc_pkg::REG_CAM_X, cx);
    write_reg(drc_pkg::REG_CAM_Y, cy);
    write_reg(drc_pkg::REG_DIR_X, dxv);
    write_reg(drc_pkg::REG_DIR_Y, dyv);
    write_reg(drc_pkg::REG_PLANE_X, px);
    write_reg(drc_pkg::REG_PLANE_Y, py);
  endtask

  // Offer one item, wait for it to be taken, record its expected result or map write, then maybe pause.
  task automatic send_item(input drc_pkg::drc_in_t item, input bit typed,
                           input drc_pkg::drc_out_t want);
    int gap, pick;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.action == drc_pkg::ActCast) begin
      pending_spans.push_back(typed ? want : trace_column(item.column));
    end else begin
      cell_map[item.cell_x*MapSize+item.cell_y] = item.cell_value;
    end
    pick = $urandom_range(0, 99);
    gap = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic drc_pkg::drc_in_t rand_item();
    drc_pkg::drc_in_t it;
    int pick;
    it = drc_pkg::drc_in_t'(InW'($urandom));
    it.action = ($urandom_range(0, 99) < 65) ? drc_pkg::ActCast : drc_pkg::ActWrite;
    it.column = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(640, 1023)) :
                                             10'($urandom_range(0, 639));
    pick = $urandom_range(0, 99);
    it.cell_value = (pick < 45) ? 8'd0 : (pick < 85) ? 8'($urandom_range(1, 4)) :
                    8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic drc_pkg::drc_in_t mk_write(input int x, y, v);
    drc_pkg::drc_in_t it;
    it = '0;
    it.action = drc_pkg::ActWrite;
    it.cell_x = 5'(x);
    it.cell_y = 5'(y);
    it.cell_value = 8'(v);
    return it;
  endfunction

  function automatic drc_pkg::drc_in_t mk_cast(input int col);
    drc_pkg::drc_in_t it;
    it = '0;
    it.action = drc_pkg::ActCast;
    it.column = 10'(col);
    return it;
  endfunction

  task automatic add_row(input drc_pkg::drc_in_t it, input bit typed = 1'b0,
                         input drc_pkg::drc_out_t want = '0);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  // Receiver: random stall stretches, plus one long hold on request.
  initial begin
    int hold, run;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
      end
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
    end
  end

  // Result checker against the oldest expected stripe.
  always @(posedge clk_i) begin
    drc_pkg::drc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = pending_spans.pop_front();
        if (out_data_o.out_column !== want.out_column ||
            out_data_o.span_start !== want.span_start ||
            out_data_o.span_end !== want.span_end ||
            out_data_o.wall_code !== want.wall_code ||
            out_data_o.palette_index !== want.palette_index ||
            out_data_o.hit_side !== want.hit_side) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p, got %p", want, out_data_o);
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("dda_raycast_column_core_tb failed");
    $finish;
  end

  // Main sequence: directed table, then random phases with new camera setups.
  initial begin
    drc_pkg::drc_out_t want;
    mismatches = 0;
    long_hold_req = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cam_x = drc_pkg::CamXRst;
    cam_y = drc_pkg::CamYRst;
    dir_x = drc_pkg::DirXRst;
    dir_y = drc_pkg::DirYRst;
    plane_x = drc_pkg::PlaneXRst;
    plane_y = drc_pkg::PlaneYRst;
    foreach (cell_map[i]) cell_map[i] = 8'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty map, center column: runs out of the grid after ten cells.
    want = '{out_column: 10'd320, span_start: 10'd288, span_end: 10'd352,
             wall_code: 8'd0, palette_index: 3'd4, hit_side: 1'b0};
    add_row(mk_cast(320), 1'b1, want);
    add_row(mk_cast(0));
    add_row(mk_cast(639));
    add_row(mk_cast(1023));
    // Wall right next to the camera: zero distance saturates the height.
    add_row(mk_write(9, 14, 2));
    want = '{out_column: 10'd320, span_start: 10'd0, span_end: 10'd639,
             wall_code: 8'd2, palette_index: 3'd1, hit_side: 1'b0};
    add_row(mk_cast(320), 1'b1, want);
    add_row(mk_write(31, 31, 255));
    add_row(mk_write(0, 0, 1));
    add_row(mk_write(9, 14, 0));
    add_row(mk_write(5, 14, 1));
    add_row(mk_cast(320));
    add_row(mk_write(5, 14, 3));
    add_row(mk_cast(320));
    add_row(mk_write(5, 14, 4));
    add_row(mk_cast(320));
    add_row(mk_write(5, 14, 255));
    add_row(mk_cast(320));
    add_row(mk_write(5, 12, 7));
    add_row(mk_cast(100));
    add_row(mk_cast(540));
    // The camera cell itself is never tested.
    add_row(mk_write(10, 14, 9));
    add_row(mk_cast(320));
    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].typed,
                                     stim_rows[i].want);
    in_valid_i <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      unique case (phase)
        0: load_camera(0, 8191, 32767, -32768, -32768, 32767);
        1: load_camera(8191, 0, -32768, 32767, 32767, -32768);
        2: load_camera($urandom_range(256, 7935), $urandom_range(256, 7935),
                       0, 16384, 0, 0);
        default: load_camera($urandom_range(0, 8191), $urandom_range(0, 8191),
                             $signed(16'($urandom)), $signed(16'($urandom)),
                             $signed(16'($urandom)), $signed(16'($urandom)));
      endcase
      if (phase == 3) begin
        write_reg(drc_pkg::REG_RSVD_6, $urandom);
        write_reg(drc_pkg::REG_RSVD_7, $urandom);
      end
      for (int n = 0; n < 200; n++) begin
        if (phase == 4 && n == 40) long_hold_req = 1'b1;
        if (phase == 4 && n == 120) begin
          in_valid_i <= 1'b0;
          while (pending_spans.size() != 0) @(posedge clk_i);
        end
        send_item(rand_item(), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("dda_raycast_column_core_tb passed");
    end else begin
      $display("dda_raycast_column_core_tb failed");
    end
    $finish;
  end

endmodule
